>>> sv/ps2kst_pkg.sv
// Shared types and constants for the PS/2 key state tracker.
`timescale 1ns / 1ps

package ps2kst_pkg;

  localparam int unsigned FrameBits = 11;
  localparam int unsigned CntW      = 4;
  localparam int unsigned CodeW     = 9;

  localparam logic [CntW-1:0] FrameBitsCnt = CntW'(FrameBits);

  // op codes of an input item
  localparam logic OP_CLOCK = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // prefix bytes
  localparam logic [7:0] BYTE_RELEASE  = 8'hF0;
  localparam logic [7:0] BYTE_EXTENDED = 8'hE0;

  typedef struct packed {
    logic       op;
    logic       data_bit;
    logic [7:0] query_code;
    logic       query_extended;
  } in_item_t;

  typedef struct packed {
    logic             key_pressed;
    logic             frame_good;
    logic             frame_bad;
    logic             key_event;
    logic [CodeW-1:0] event_code;
    logic             event_release;
  } out_item_t;

  // frame checker status toward the decoder
  typedef struct packed {
    logic       good;
    logic       bad;
    logic [7:0] data;
  } frame_res_t;

endpackage

>>> sv/ps2kst_if.sv
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps

interface ps2kst_in_if import ps2kst_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface ps2kst_out_if import ps2kst_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

>>> sv/ps2_key_state_tracker.sv
// Top level of the PS/2 key state tracker: frame check, prefix decode, key map.
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle; a new item is taken while a result waits if
//   the output register is drained in the same cycle.
// Reset: frame window, bit count, parity, prefixes and all 512 key bits clear at once.
`timescale 1ns / 1ps

module ps2_key_state_tracker import ps2kst_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ps2kst_in_if.sink    in_i,
  ps2kst_out_if.source out_o
);

  localparam int unsigned MapBits = 1 << CodeW;

  logic accept;
  logic bit_en;

  frame_res_t frame_res;

  // Prefix flags armed by F0 / E0, dropped by the next key byte
  logic rel_pend_q, rel_pend_d;
  logic ext_pend_q, ext_pend_d;

  // Pressed-key bitmap, one flop per key so reset clears the whole map at once
  logic [MapBits-1:0] key_map_q;
  logic               map_we;
  logic [CodeW-1:0]   map_idx;

  // Result register
  out_item_t out_q, out_d;
  logic      out_valid_q;

  // Take a new item whenever the result register is empty or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign bit_en     = accept && (in_i.item.op == OP_CLOCK);

  ps2kst_frame u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bit_en_i   (bit_en),
    .data_bit_i (in_i.item.data_bit),
    .res_o      (frame_res)
  );

  // Decode: queries read the map; prefix bytes only arm flags, any other good byte updates the map
  always_comb begin
    rel_pend_d = rel_pend_q;
    ext_pend_d = ext_pend_q;
    map_we     = 1'b0;
    map_idx    = {ext_pend_q, frame_res.data};
    out_d      = '0;

    if (in_i.item.op == OP_QUERY) begin
      out_d.key_pressed = key_map_q[{in_i.item.query_extended, in_i.item.query_code}];
    end else begin
      out_d.frame_good = frame_res.good;
      out_d.frame_bad  = frame_res.bad;
      if (frame_res.good) begin
        if (frame_res.data == BYTE_RELEASE) begin
          rel_pend_d = 1'b1;
        end else if (frame_res.data == BYTE_EXTENDED) begin
          ext_pend_d = 1'b1;
        end else begin
          map_we              = 1'b1;
          out_d.key_event     = 1'b1;
          out_d.event_code    = map_idx;
          out_d.event_release = rel_pend_q;
          rel_pend_d          = 1'b0;
          ext_pend_d          = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_pend_q <= 1'b0;
      ext_pend_q <= 1'b0;
      key_map_q  <= '0;
    end else if (bit_en) begin
      rel_pend_q <= rel_pend_d;
      ext_pend_q <= ext_pend_d;
      if (map_we) begin
        // release clears the key, press sets it
        key_map_q[map_idx] <= !rel_pend_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

  // A reported key event always comes from a good frame
  a_event_needs_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.key_event |-> out_q.frame_good && !out_q.frame_bad)
    else $error("key event without a good frame");

  // A query answer reporting a pressed key never carries frame status or a key event
  a_query_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.key_pressed |-> !out_q.frame_good && !out_q.frame_bad
      && !out_q.key_event)
    else $error("query result carries frame status");

  // The map bit of an event reflects press or release right after it
  a_map_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_en && map_we |=> key_map_q[$past(map_idx)] == !$past(rel_pend_q))
    else $error("key map not updated by key event");

  // Both prefixes drop after a key byte
  a_prefix_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_en && map_we |=> !rel_pend_q && !ext_pend_q)
    else $error("prefix flags not cleared after key event");

endmodule

>>> sv/ps2kst_frame.sv
// Serial frame window, parity tracking and start/stop/parity check.
`timescale 1ns / 1ps

module ps2kst_frame import ps2kst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       bit_en_i,
  input  logic       data_bit_i,
  output frame_res_t res_o
);

  logic [FrameBits-1:0] win_q, win_d;
  logic [CntW-1:0]      cnt_q, cnt_d, cnt_inc;
  logic                 par_q, par_d;
  logic                 check;

  always_comb begin
    par_d   = par_q ^ win_q[0] ^ data_bit_i;
    win_d   = {data_bit_i, win_q[FrameBits-1:1]};
    cnt_inc = (cnt_q < FrameBitsCnt) ? cnt_q + CntW'(1) : cnt_q;
    check   = (cnt_inc == FrameBitsCnt);

    res_o.good = check && !win_d[0] && win_d[FrameBits-1] && !par_d;
    res_o.bad  = check && !res_o.good;
    res_o.data = win_d[8:1];

    // good frame restarts; bad frame parks at full so every later bit rechecks
    if (res_o.good) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      cnt_q <= '0;
      par_q <= 1'b0;
    end else if (bit_en_i) begin
      win_q <= win_d;
      cnt_q <= cnt_d;
      par_q <= par_d;
    end
  end

endmodule
